// ----- sv/assert_macros.svh -----
// Assertion macros used by the complex arithmetic unit back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CAU_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CAU_ASSERT(lbl, prop, msg)
`define CAU_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- sv/cau_pkg.sv -----
// Types and constants shared by the complex arithmetic unit pipeline.
package cau_pkg;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	localparam int QUO_W      = 32;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = QUO_W / DIV_STEPS;

	localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

	typedef struct packed {
		kind_t        kind;
		logic         neg_re;
		logic         neg_im;
		logic [63:0]  mag_re;
		logic [63:0]  mag_im;
		logic [63:0]  den;
		logic         dz;
		logic         dov_re;
		logic         dov_im;
		logic [64:0]  rem_re;
		logic [64:0]  rem_im;
		logic [31:0]  dlo_re;
		logic [31:0]  dlo_im;
		logic [31:0]  q_re;
		logic [31:0]  q_im;
	} pipe_t;

endpackage

// ----- sv/cau_front.sv -----
// Front end: products, sums, sign and magnitude, and divider setup (four stages).
module cau_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                req_valid,
	input  logic [1:0]          kind,
	input  logic signed [31:0]  a_real,
	input  logic signed [31:0]  a_imag,
	input  logic signed [31:0]  b_real,
	input  logic signed [31:0]  b_imag,
	output logic                valid_o,
	output cau_pkg::pipe_t      stage_o
);

	logic                valid_s1, valid_s2, valid_s3;
	cau_pkg::kind_t      kind_s1, kind_s2, kind_s3;
	logic signed [63:0]  p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [63:0]  sq_r_s1, sq_i_s1;
	logic signed [32:0]  sum_re_s1, sum_im_s1;
	logic signed [64:0]  val_re_s2, val_im_s2;
	logic [63:0]         den_s2, den_s3;
	logic                neg_re_s3, neg_im_s3, dz_s3;
	logic [63:0]         mag_re_s3, mag_im_s3;
	logic signed [64:0]  val_re_c, val_im_c;
	logic [63:0]         abs_re_c, abs_im_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_o  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_o  <= valid_s3;
		end
	end

	// Stage 1: the six 32 by 32 products and the add or subtract sums.
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= cau_pkg::kind_t'(kind);
			p_rr_s1 <= a_real * b_real;
			p_ii_s1 <= a_imag * b_imag;
			p_ri_s1 <= a_real * b_imag;
			p_ir_s1 <= a_imag * b_real;
			sq_r_s1 <= b_real * b_real;
			sq_i_s1 <= b_imag * b_imag;
			if (kind == cau_pkg::KIND_SUB) begin
				sum_re_s1 <= 33'(a_real) - 33'(b_real);
				sum_im_s1 <= 33'(a_imag) - 33'(b_imag);
			end else begin
				sum_re_s1 <= 33'(a_real) + 33'(b_real);
				sum_im_s1 <= 33'(a_imag) + 33'(b_imag);
			end
		end
	end

	always_comb begin
		unique case (kind_s1)
			cau_pkg::KIND_ADD, cau_pkg::KIND_SUB: begin
				val_re_c = 65'(sum_re_s1);
				val_im_c = 65'(sum_im_s1);
			end
			cau_pkg::KIND_MUL: begin
				val_re_c = 65'(p_rr_s1) - 65'(p_ii_s1);
				val_im_c = 65'(p_ri_s1) + 65'(p_ir_s1);
			end
			default: begin
				val_re_c = 65'(p_rr_s1) + 65'(p_ii_s1);
				val_im_c = 65'(p_ir_s1) - 65'(p_ri_s1);
			end
		endcase
	end

	// Stage 2: exact 65-bit component values and the divisor, the squared magnitude of b.
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2   <= kind_s1;
			val_re_s2 <= val_re_c;
			val_im_s2 <= val_im_c;
			den_s2    <= 64'(sq_r_s1) + 64'(sq_i_s1);
		end
	end

	assign abs_re_c = val_re_s2[64] ? 64'(-val_re_s2) : val_re_s2[63:0];
	assign abs_im_c = val_im_s2[64] ? 64'(-val_im_s2) : val_im_s2[63:0];

	// Stage 3: sign and magnitude; products drop sixteen fraction bits.
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s3   <= kind_s2;
			neg_re_s3 <= val_re_s2[64];
			neg_im_s3 <= val_im_s2[64];
			den_s3    <= den_s2;
			dz_s3     <= (kind_s2 == cau_pkg::KIND_DIV) && (den_s2 == 64'd0);
			if (kind_s2 == cau_pkg::KIND_MUL) begin
				mag_re_s3 <= abs_re_c >> 16;
				mag_im_s3 <= abs_im_c >> 16;
			end else begin
				mag_re_s3 <= abs_re_c;
				mag_im_s3 <= abs_im_c;
			end
		end
	end

	// Stage 4: a quotient of 2^16 or more saturates; otherwise the divider
	// starts from the dividend bits above the sixteen fraction positions.
	always_ff @(posedge clk) begin
		if (adv) begin
			stage_o.kind   <= kind_s3;
			stage_o.neg_re <= neg_re_s3;
			stage_o.neg_im <= neg_im_s3;
			stage_o.mag_re <= mag_re_s3;
			stage_o.mag_im <= mag_im_s3;
			stage_o.den    <= den_s3;
			stage_o.dz     <= dz_s3;
			stage_o.dov_re <= {16'd0, mag_re_s3} >= {den_s3, 16'd0};
			stage_o.dov_im <= {16'd0, mag_im_s3} >= {den_s3, 16'd0};
			stage_o.rem_re <= {17'd0, mag_re_s3[63:16]};
			stage_o.rem_im <= {17'd0, mag_im_s3[63:16]};
			stage_o.dlo_re <= {mag_re_s3[15:0], 16'd0};
			stage_o.dlo_im <= {mag_im_s3[15:0], 16'd0};
			stage_o.q_re   <= '0;
			stage_o.q_im   <= '0;
		end
	end

endmodule

// ----- sv/cau_div_stage.sv -----
// One restoring divider stage: DIV_STEPS (two) quotient bits for both components.
module cau_div_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            valid_i,
	input  cau_pkg::pipe_t  stage_i,
	output logic            valid_o,
	output cau_pkg::pipe_t  stage_o
);

	logic            valid_s1;
	cau_pkg::pipe_t  pipe_s1;
	cau_pkg::pipe_t  nxt;

	always_comb begin
		logic [64:0] t_re;
		logic [64:0] t_im;
		logic        ge_re;
		logic        ge_im;
		nxt = stage_i;
		for (int i = 0; i < cau_pkg::DIV_STEPS; i++) begin
			t_re  = {nxt.rem_re[63:0], nxt.dlo_re[31]};
			t_im  = {nxt.rem_im[63:0], nxt.dlo_im[31]};
			ge_re = t_re >= {1'b0, nxt.den};
			ge_im = t_im >= {1'b0, nxt.den};
			nxt.rem_re = ge_re ? t_re - {1'b0, nxt.den} : t_re;
			nxt.rem_im = ge_im ? t_im - {1'b0, nxt.den} : t_im;
			nxt.q_re   = {nxt.q_re[30:0], ge_re};
			nxt.q_im   = {nxt.q_im[30:0], ge_im};
			nxt.dlo_re = {nxt.dlo_re[30:0], 1'b0};
			nxt.dlo_im = {nxt.dlo_im[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s1 <= nxt;
		end
	end

	assign valid_o = valid_s1;
	assign stage_o = pipe_s1;

endmodule

// ----- sv/cau_back.sv -----
// Back end: result selection, saturation to Q16.16 and the output register.
`include "assert_macros.svh"

module cau_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                valid_i,
	input  cau_pkg::pipe_t      stage_i,
	output logic                res_valid,
	output logic signed [31:0]  res_real,
	output logic signed [31:0]  res_imag,
	output logic                overflow,
	output logic                div_zero
);

	logic         valid_q;
	logic [31:0]  res_real_q, res_imag_q;
	logic         overflow_q, div_zero_q;
	logic [63:0]  fin_re, fin_im;
	logic         neg_re, neg_im;
	logic [32:0]  nar_re, nar_im;

	// Bit 32 of the result flags saturation.
	function automatic logic [32:0] narrow(input logic neg, input logic [63:0] mag);
		logic [31:0] low;
		low = mag[31:0];
		if (!neg) begin
			if (mag > 64'(cau_pkg::POS_LIMIT)) begin
				narrow = {1'b1, cau_pkg::POS_LIMIT};
			end else begin
				narrow = {1'b0, low};
			end
		end else if (mag > 64'(cau_pkg::NEG_LIMIT)) begin
			narrow = {1'b1, cau_pkg::NEG_LIMIT};
		end else begin
			narrow = {1'b0, ~low + 32'd1};
		end
	endfunction

	always_comb begin
		neg_re = stage_i.neg_re;
		neg_im = stage_i.neg_im;
		if (stage_i.kind == cau_pkg::KIND_DIV) begin
			if (stage_i.dz) begin
				fin_re = '0;
				fin_im = '0;
				neg_re = 1'b0;
				neg_im = 1'b0;
			end else begin
				fin_re = stage_i.dov_re ? 64'h1_0000_0000 : {32'd0, stage_i.q_re};
				fin_im = stage_i.dov_im ? 64'h1_0000_0000 : {32'd0, stage_i.q_im};
			end
		end else begin
			fin_re = stage_i.mag_re;
			fin_im = stage_i.mag_im;
		end
		nar_re = narrow(neg_re, fin_re);
		nar_im = narrow(neg_im, fin_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_real_q <= nar_re[31:0];
			res_imag_q <= nar_im[31:0];
			overflow_q <= nar_re[32] | nar_im[32];
			div_zero_q <= stage_i.dz;
		end
	end

	assign res_valid = valid_q;
	assign res_real  = res_real_q;
	assign res_imag  = res_imag_q;
	assign overflow  = overflow_q;
	assign div_zero  = div_zero_q;

	`CAU_ASSERT(a_dz_zero, valid_q && div_zero_q |-> res_real_q == '0 && res_imag_q == '0, "divide by zero beat has a nonzero result")
	`CAU_ASSERT_NEVER(a_dz_no_ovf, valid_q && div_zero_q && overflow_q, "divide by zero beat also flags overflow")
	`CAU_ASSERT(a_ovf_sat, valid_q && overflow_q |-> (res_real_q == cau_pkg::POS_LIMIT || res_real_q == cau_pkg::NEG_LIMIT || res_imag_q == cau_pkg::POS_LIMIT || res_imag_q == cau_pkg::NEG_LIMIT), "overflow beat without a saturated component")

endmodule

// ----- sv/complex_arith_unit_core.sv -----
// Complex add, subtract, multiply and divide in signed Q16.16, fully pipelined.
// Every operation passes through four front stages, sixteen divider
// stages of two quotient bits each, and the output register.
// Throughput is one beat per cycle; a stall at the output freezes the whole pipe.
// Reset clears only the valid bits; the data registers are not reset.
module complex_arith_unit_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          kind,
	input  logic signed [31:0]  a_real,
	input  logic signed [31:0]  a_imag,
	input  logic signed [31:0]  b_real,
	input  logic signed [31:0]  b_imag,
	output logic                res_valid,
	input  logic                res_stall,
	output logic signed [31:0]  res_real,
	output logic signed [31:0]  res_imag,
	output logic                overflow,
	output logic                div_zero
);

	logic                              adv;
	cau_pkg::pipe_t                    stg [cau_pkg::DIV_STAGES+1];
	logic [cau_pkg::DIV_STAGES:0]      stg_v;

	assign adv       = !(res_valid && res_stall);
	assign req_stall = !adv;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req_valid (req_valid),
		.kind      (kind),
		.a_real    (a_real),
		.a_imag    (a_imag),
		.b_real    (b_real),
		.b_imag    (b_imag),
		.valid_o   (stg_v[0]),
		.stage_o   (stg[0])
	);

	for (genvar g = 0; g < cau_pkg::DIV_STAGES; g++) begin : g_div
		cau_div_stage u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.valid_i (stg_v[g]),
			.stage_i (stg[g]),
			.valid_o (stg_v[g+1]),
			.stage_o (stg[g+1])
		);
	end

	cau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_i   (stg_v[cau_pkg::DIV_STAGES]),
		.stage_i   (stg[cau_pkg::DIV_STAGES]),
		.res_valid (res_valid),
		.res_real  (res_real),
		.res_imag  (res_imag),
		.overflow  (overflow),
		.div_zero  (div_zero)
	);

endmodule

// ----- tb/complex_arith_unit_core_test.sv -----
// Self-checking testbench for the complex arithmetic unit core.
`timescale 1ns / 1ps

module complex_arith_unit_core_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        ovf;
		logic        dz;
	} cplx_result_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [1:0] kind;
	logic signed [31:0] a_real;
	logic signed [31:0] a_imag;
	logic signed [31:0] b_real;
	logic signed [31:0] b_imag;
	logic res_valid;
	logic res_stall;
	logic signed [31:0] res_real;
	logic signed [31:0] res_imag;
	logic overflow;
	logic div_zero;

	cplx_result_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	int checked = 0;
	int kind_count[4] = '{0, 0, 0, 0};
	int ovf_seen = 0;
	int dz_seen = 0;
	bit steady = 0;

	complex_arith_unit_core u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.kind(kind), .a_real(a_real), .a_imag(a_imag),
		.b_real(b_real), .b_imag(b_imag),
		.res_valid(res_valid), .res_stall(res_stall),
		.res_real(res_real), .res_imag(res_imag),
		.overflow(overflow), .div_zero(div_zero)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Products are truncated toward zero when dropping the 16 fraction bits.
	function automatic logic signed [127:0] drop_fraction(input logic signed [127:0] v);
		if (v < 0) return -((-v) >>> 16);
		return v >>> 16;
	endfunction

	function automatic logic signed [127:0] divide_q16(input logic signed [127:0] num,
			input logic [127:0] den);
		logic [127:0] mag;
		logic [127:0] q;
		mag = (num < 0) ? -num : num;
		q = (mag << 16) / den;
		return (num < 0) ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic [31:0] clamp_q16(input logic signed [127:0] v, inout logic ovf);
		if (v > 128'sh7FFF_FFFF) begin
			ovf = 1'b1;
			return cau_pkg::POS_LIMIT;
		end
		if (v < -128'sh8000_0000) begin
			ovf = 1'b1;
			return cau_pkg::NEG_LIMIT;
		end
		return v[31:0];
	endfunction

	function automatic cplx_result_t predict_result(input cau_pkg::kind_t op,
			input logic signed [31:0] ar, ai, br, bi);
		cplx_result_t r;
		logic signed [127:0] war, wai, wbr, wbi, vre, vim;
		logic [127:0] den;
		war = ar; wai = ai; wbr = br; wbi = bi;
		r.ovf = 1'b0;
		r.dz = 1'b0;
		vre = 0;
		vim = 0;
		unique case (op)
			cau_pkg::KIND_ADD: begin
				vre = war + wbr;
				vim = wai + wbi;
			end
			cau_pkg::KIND_SUB: begin
				vre = war - wbr;
				vim = wai - wbi;
			end
			cau_pkg::KIND_MUL: begin
				vre = drop_fraction(war * wbr - wai * wbi);
				vim = drop_fraction(war * wbi + wai * wbr);
			end
			default: begin
				den = wbr * wbr + wbi * wbi;
				if (den == 0) r.dz = 1'b1;
				else begin
					vre = divide_q16(war * wbr + wai * wbi, den);
					vim = divide_q16(wai * wbr - war * wbi, den);
				end
			end
		endcase
		r.re = clamp_q16(vre, r.ovf);
		r.im = clamp_q16(vim, r.ovf);
		return r;
	endfunction

	// Each cycle is idle with a chance of about one in four.
	function automatic int idle_gap();
		int gap;
		gap = 0;
		if (steady) return 0;
		while ($urandom_range(0, 99) < 26) gap++;
		return gap;
	endfunction

	task automatic send_item(input cau_pkg::kind_t op, input logic [31:0] ar, ai, br, bi);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= op;
		a_real <= ar;
		a_imag <= ai;
		b_real <= br;
		b_imag <= bi;
		do @(posedge clk); while (req_stall);
		pending_results.push_back(predict_result(op, ar, ai, br, bi));
		kind_count[op]++;
	endtask

	function automatic logic [31:0] random_operand();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
			2: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
			3: begin
				case ($urandom_range(0, 4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0;
					3: return 32'h0001_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
		endcase
	endfunction

	task automatic test_directed();
		cau_pkg::kind_t op;
		send_item(cau_pkg::KIND_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
		send_item(cau_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		send_item(cau_pkg::KIND_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(cau_pkg::KIND_SUB, 32'h0005_8000, 32'h0000_0000, 32'h0002_4000, 32'h0001_0000);
		send_item(cau_pkg::KIND_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		send_item(cau_pkg::KIND_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);
		send_item(cau_pkg::KIND_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFB_0000);
		send_item(cau_pkg::KIND_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000, 32'h0000_8000);
		send_item(cau_pkg::KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_item(cau_pkg::KIND_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(cau_pkg::KIND_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
		send_item(cau_pkg::KIND_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
		send_item(cau_pkg::KIND_DIV, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0002_0000);
		send_item(cau_pkg::KIND_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
		send_item(cau_pkg::KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
		send_item(cau_pkg::KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_item(cau_pkg::KIND_DIV, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		// The most negative quotient lands exactly on the lower limit.
		send_item(cau_pkg::KIND_DIV, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'h0);
		send_item(cau_pkg::KIND_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
		for (int i = 0; i < 4; i++) begin
			op = cau_pkg::kind_t'(i);
			send_item(op, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		end
	endtask

	task automatic test_random(input int count);
		logic [31:0] br, bi;
		for (int i = 0; i < count; i++) begin
			// A stretch in the middle runs at full rate on both sides.
			steady = (i >= count / 3) && (i < count / 3 + 150);
			br = random_operand();
			bi = random_operand();
			if ($urandom_range(0, 19) == 0) begin
				br = 0;
				bi = 0;
			end
			send_item(cau_pkg::kind_t'($urandom_range(0, 3)), random_operand(),
				random_operand(), br, bi);
		end
		steady = 0;
		req_valid <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= !steady && ($urandom_range(0, 99) < 26);
		end
	end

	always @(posedge clk) begin
		cplx_result_t exp_res;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat re=%h im=%h", $time, res_real, res_imag);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				checked++;
				if (res_real !== exp_res.re || res_imag !== exp_res.im ||
						overflow !== exp_res.ovf || div_zero !== exp_res.dz) begin
					$display("%0t: mismatch expected re=%h im=%h ovf=%b dz=%b, actual re=%h im=%h ovf=%b dz=%b",
						$time, exp_res.re, exp_res.im, exp_res.ovf, exp_res.dz,
						res_real, res_imag, overflow, div_zero);
					errors++;
				end
				ovf_seen += exp_res.ovf;
				dz_seen += exp_res.dz;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		kind = cau_pkg::KIND_ADD;
		a_real = 0;
		a_imag = 0;
		b_real = 0;
		b_imag = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(930);
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d results: add %0d, sub %0d, mul %0d, div %0d beats.",
			checked, kind_count[cau_pkg::KIND_ADD], kind_count[cau_pkg::KIND_SUB],
			kind_count[cau_pkg::KIND_MUL], kind_count[cau_pkg::KIND_DIV]);
		$display("Saturated results: %0d, divide-by-zero results: %0d.", ovf_seen, dz_seen);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
